>>> src/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for rational_arith_reduce
// Operation codes, output and work widths, and back-end state encoding.
// ----------------------------------------------------------------------------
package rar_pkg;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_MUL  = 2'd1,
        ACT_DIV  = 2'd2,
        ACT_PASS = 2'd3
    } action_t;

    localparam int NUM_OUT_WIDTH = 33;
    localparam int DEN_OUT_WIDTH = 32;
    localparam int WORK_WIDTH    = 64;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_MUL1,
        BE_MUL2,
        BE_SUM,
        BE_GCD,
        BE_DIVN,
        BE_DIVD,
        BE_OUT
    } be_state_t;

endpackage

>>> src/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front: input stage and item queue
// Accepts items, decodes the operation into operand pairs and holds them in
// a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rar_front #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      in_action,
    input  logic signed [OPERAND_WIDTH-1:0] in_an,
    input  logic signed [OPERAND_WIDTH-1:0] in_ad,
    input  logic signed [OPERAND_WIDTH-1:0] in_bn,
    input  logic signed [OPERAND_WIDTH-1:0] in_bd,
    output logic                            q_valid,
    input  logic                            q_ready,
    output logic [1:0]                      q_action,
    // product operands: p0=x0*y0, p1=x1*y1, p2=x2*y2 (add uses p0+p1 and p2)
    output logic signed [OPERAND_WIDTH-1:0] q_x0,
    output logic signed [OPERAND_WIDTH-1:0] q_y0,
    output logic signed [OPERAND_WIDTH-1:0] q_x1,
    output logic signed [OPERAND_WIDTH-1:0] q_y1,
    output logic signed [OPERAND_WIDTH-1:0] q_x2,
    output logic signed [OPERAND_WIDTH-1:0] q_y2
);
    localparam int EW = 2 + 6 * OPERAND_WIDTH;

    logic [EW-1:0] ent_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next, wr_reg, wr_next;
    logic [EW-1:0] ent_in;
    logic          push, pop;
    logic signed [OPERAND_WIDTH-1:0] x0, y0, x1, y1, x2, y2;

    // classify: route operands to multiplier pairs
    always_comb begin
        x0 = in_an; y0 = in_bd; x1 = in_bn; y1 = in_ad; x2 = in_ad; y2 = in_bd;
        unique case (rar_pkg::action_t'(in_action))
            rar_pkg::ACT_ADD: begin
                x0 = in_an; y0 = in_bd; x1 = in_bn; y1 = in_ad;
            end
            rar_pkg::ACT_MUL: begin
                x0 = in_an; y0 = in_bn;
            end
            rar_pkg::ACT_DIV: begin
                x0 = in_an; y0 = in_bd; x2 = in_ad; y2 = in_bn;
            end
            default: begin
                x0 = in_an; y0 = OPERAND_WIDTH'(1); x2 = in_ad; y2 = OPERAND_WIDTH'(1);
            end
        endcase
    end

    assign ent_in   = {in_action, x0, y0, x1, y1, x2, y2};
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign {q_action, q_x0, q_y0, q_x1, q_y1, q_x2, q_y2} = ent_reg[rd_reg];

    // queue pointers
    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (push) begin
            wr_next = ~wr_reg;
        end
        if (pop) begin
            rd_next = ~rd_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= ent_in;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
endmodule

>>> src/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back: arithmetic and reduction engine
// Forms raw products; for positive terms runs a binary gcd one step per cycle,
// then divides both by it in a shared restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rar_back #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [1:0]                      q_action,
    input  logic signed [OPERAND_WIDTH-1:0] q_x0,
    input  logic signed [OPERAND_WIDTH-1:0] q_y0,
    input  logic signed [OPERAND_WIDTH-1:0] q_x1,
    input  logic signed [OPERAND_WIDTH-1:0] q_y1,
    input  logic signed [OPERAND_WIDTH-1:0] q_x2,
    input  logic signed [OPERAND_WIDTH-1:0] q_y2,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rar_pkg::NUM_OUT_WIDTH-1:0] out_num,
    output logic [rar_pkg::DEN_OUT_WIDTH-1:0] out_den
);
    localparam int W  = rar_pkg::WORK_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int NUM_OUT_W = rar_pkg::NUM_OUT_WIDTH;

    rar_pkg::be_state_t st_reg, st_next;
    logic [1:0]          act_reg;
    logic signed [OPERAND_WIDTH-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic [W-1:0] num_reg, den_reg, ga_reg, gb_reg, g_reg;
    logic [W-1:0] quo_reg, rem_reg, dvd_reg;
    logic [CW-1:0] sh_reg, cnt_reg;
    logic [NUM_OUT_W-1:0] onum_reg;
    logic [rar_pkg::DEN_OUT_WIDTH-1:0] oden_reg;
    logic ovalid_reg;
    logic [W-1:0] rem_sh, dsub;
    logic [W-1:0] gdiff;

    assign q_ready   = (st_reg == rar_pkg::BE_IDLE);
    assign out_valid = ovalid_reg;
    assign out_num   = onum_reg;
    assign out_den   = oden_reg;

    // shared divider step: shift one dividend bit into the remainder
    assign rem_sh = {rem_reg[W-2:0], dvd_reg[W-1]};
    assign dsub   = rem_sh - g_reg;
    assign gdiff  = (ga_reg > gb_reg) ? ga_reg - gb_reg : gb_reg - ga_reg;

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            rar_pkg::BE_IDLE: if (q_valid) st_next = rar_pkg::BE_MUL1;
            rar_pkg::BE_MUL1: st_next = rar_pkg::BE_MUL2;
            rar_pkg::BE_MUL2: st_next = rar_pkg::BE_SUM;
            rar_pkg::BE_SUM:  st_next = rar_pkg::BE_GCD;
            rar_pkg::BE_GCD: begin
                if (!(num_reg != '0 && !num_reg[W-1] && den_reg != '0 && !den_reg[W-1]))
                    st_next = rar_pkg::BE_OUT;
                else if (ga_reg == gb_reg)
                    st_next = rar_pkg::BE_DIVN;
            end
            rar_pkg::BE_DIVN: if (cnt_reg == CW'(W - 1)) st_next = rar_pkg::BE_DIVD;
            rar_pkg::BE_DIVD: if (cnt_reg == CW'(W - 1)) st_next = rar_pkg::BE_OUT;
            rar_pkg::BE_OUT:  if (!ovalid_reg || out_ready) st_next = rar_pkg::BE_IDLE;
            default: st_next = rar_pkg::BE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= rar_pkg::BE_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == rar_pkg::BE_OUT && (!ovalid_reg || out_ready))
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (st_reg)
            rar_pkg::BE_IDLE: begin
                act_reg <= q_action;
                x0_reg <= q_x0; y0_reg <= q_y0; x1_reg <= q_x1;
                y1_reg <= q_y1; x2_reg <= q_x2; y2_reg <= q_y2;
            end
            rar_pkg::BE_MUL1: begin
                p0_reg <= PW'(x0_reg * y0_reg);
                p1_reg <= PW'(x1_reg * y1_reg);
            end
            rar_pkg::BE_MUL2: begin
                p2_reg <= PW'(x2_reg * y2_reg);
            end
            rar_pkg::BE_SUM: begin
                if (rar_pkg::action_t'(act_reg) == rar_pkg::ACT_ADD)
                    num_reg <= W'(p0_reg) + W'(p1_reg);
                else
                    num_reg <= W'(p0_reg);
                if (rar_pkg::action_t'(act_reg) == rar_pkg::ACT_ADD ||
                    rar_pkg::action_t'(act_reg) == rar_pkg::ACT_MUL)
                    den_reg <= W'(p2_reg);
                else
                    den_reg <= W'(p2_reg);
                ga_reg <= (rar_pkg::action_t'(act_reg) == rar_pkg::ACT_ADD)
                          ? W'(p0_reg) + W'(p1_reg) : W'(p0_reg);
                gb_reg <= W'(p2_reg);
                sh_reg <= '0;
            end
            rar_pkg::BE_GCD: begin
                // binary gcd: strip common twos, then subtract
                if (ga_reg != gb_reg) begin
                    if (!ga_reg[0] && !gb_reg[0]) begin
                        ga_reg <= ga_reg >> 1; gb_reg <= gb_reg >> 1; sh_reg <= sh_reg + 1'b1;
                    end else if (!ga_reg[0]) begin
                        ga_reg <= ga_reg >> 1;
                    end else if (!gb_reg[0]) begin
                        gb_reg <= gb_reg >> 1;
                    end else if (ga_reg > gb_reg) begin
                        ga_reg <= gdiff >> 1;
                    end else begin
                        gb_reg <= gdiff >> 1;
                    end
                end else begin
                    g_reg   <= ga_reg << sh_reg;
                    dvd_reg <= num_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            rar_pkg::BE_DIVN, rar_pkg::BE_DIVD: begin
                if (rem_sh >= g_reg) begin
                    rem_reg <= dsub;
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                    dvd_reg <= den_reg;
                    if (st_reg == rar_pkg::BE_DIVN)
                        num_reg <= {quo_reg[W-2:0], rem_sh >= g_reg};
                    else
                        den_reg <= {quo_reg[W-2:0], rem_sh >= g_reg};
                end
            end
            rar_pkg::BE_OUT: begin
                if (!ovalid_reg || out_ready) begin
                    onum_reg <= num_reg[NUM_OUT_W-1:0];
                    oden_reg <= den_reg[rar_pkg::DEN_OUT_WIDTH-1:0];
                end
            end
            default: ;
        endcase
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_gcd_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == rar_pkg::BE_DIVN |-> g_reg != '0) else $error("zero divisor");
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> st_reg == rar_pkg::BE_IDLE) else $error("ready outside idle");
endmodule

>>> src/rational_arith_reduce_top.sv
// An accepted item leaves the queue and passes the product, sum and gcd
//   states to the output register; when both terms are positive, the
//   binary-gcd steps and two 64-bit bit-serial divisions come first.
// Throughput: one item at a time in the back end; a two-entry queue lets the
//   next items be taken while one is worked on, and m_tready can hold it.
// Reset: aresetn synchronous, active low; clears queue and state, no result.
// ----------------------------------------------------------------------------
// rational_arith_reduce_top: fraction add/multiply/divide with gcd reduction
// Front end queues decoded items; back end multiplies and reduces.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // action[1:0], a_num, a_den, b_num, b_den (OPERAND_WIDTH each), zero pad
    input  logic [((2+4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // result_num[32:0], result_den[64:33], pad [71:65]
    output logic [71:0]                m_tdata
);
    localparam int OW = OPERAND_WIDTH;

    logic            q_valid, q_ready;
    logic [1:0]      q_action;
    logic signed [OW-1:0] q_x0, q_y0, q_x1, q_y1, q_x2, q_y2;
    logic [rar_pkg::NUM_OUT_WIDTH-1:0] rnum;
    logic [rar_pkg::DEN_OUT_WIDTH-1:0] rden;

    rar_front #(.OPERAND_WIDTH(OW)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(s_tdata[1:0]),
        .in_an(s_tdata[2+OW-1:2]),
        .in_ad(s_tdata[2+2*OW-1:2+OW]),
        .in_bn(s_tdata[2+3*OW-1:2+2*OW]),
        .in_bd(s_tdata[2+4*OW-1:2+3*OW]),
        .q_valid(q_valid), .q_ready(q_ready), .q_action(q_action),
        .q_x0(q_x0), .q_y0(q_y0), .q_x1(q_x1), .q_y1(q_y1), .q_x2(q_x2), .q_y2(q_y2)
    );

    rar_back #(.OPERAND_WIDTH(OW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_action(q_action),
        .q_x0(q_x0), .q_y0(q_y0), .q_x1(q_x1), .q_y1(q_y1), .q_x2(q_x2), .q_y2(q_y2),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_num(rnum), .out_den(rden)
    );

    assign m_tdata = {7'd0, rden, rnum};
endmodule

>>> tb/rational_arith_reduce_top_tb.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_top_tb: self-checking bench for fraction arithmetic
// Drives fraction pairs with add, multiply, divide and the pass-through code,
// predicts the gcd-reduced result and compares it field by field, in order.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = 16;
    localparam int SW = ((2 + 4 * OW + 7) / 8) * 8;

    typedef struct {
        logic [rar_pkg::NUM_OUT_WIDTH-1:0] num;
        logic [rar_pkg::DEN_OUT_WIDTH-1:0] den;
    } fraction_t;

    // Predicts reduced fractions and holds them until the block returns them
    class fraction_scoreboard;
        fraction_t pending[$];
        int        errors = 0;

        function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function void note_item(rar_pkg::action_t act, logic signed [OW-1:0] an,
                                logic signed [OW-1:0] ad, logic signed [OW-1:0] bn,
                                logic signed [OW-1:0] bd);
            logic signed [63:0] a_n, a_d, b_n, b_d, n, d;
            logic [63:0] g;
            fraction_t f;
            a_n = an;
            a_d = ad;
            b_n = bn;
            b_d = bd;
            case (act)
                rar_pkg::ACT_ADD: begin
                    n = a_n * b_d + b_n * a_d;
                    d = a_d * b_d;
                end
                rar_pkg::ACT_MUL: begin
                    n = a_n * b_n;
                    d = a_d * b_d;
                end
                rar_pkg::ACT_DIV: begin
                    n = a_n * b_d;
                    d = a_d * b_n;
                end
                default: begin
                    n = a_n;
                    d = a_d;
                end
            endcase
            // reduce only when both are strictly positive
            if (n > 0 && d > 0) begin
                g = gcd64(n, d);
                n = n / g;
                d = d / g;
            end
            f.num = n[rar_pkg::NUM_OUT_WIDTH-1:0];
            f.den = d[rar_pkg::DEN_OUT_WIDTH-1:0];
            pending.push_back(f);
        endfunction

        function void check_result(logic [71:0] data);
            fraction_t f;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            f = pending.pop_front();
            if (data[32:0] !== f.num) begin
                $error("result_num: expected %h, got %h", f.num, data[32:0]);
                errors++;
            end
            if (data[64:33] !== f.den) begin
                $error("result_den: expected %h, got %h", f.den, data[64:33]);
                errors++;
            end
        endfunction
    endclass

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [71:0]   m_tdata;

    fraction_scoreboard fsb = new();
    int burst_left = 0;

    rational_arith_reduce_top #(.OPERAND_WIDTH(OW)) dut (.*);

    initial forever #1 aclk = ~aclk;

    // Check results; receiver stalls on its own pattern, with quiet stretches
    always @(posedge aclk) begin
        int r;
        if (aresetn && m_tvalid && m_tready) fsb.check_result(m_tdata);
        r = $urandom_range(0, 99);
        if ((($time / 2000) % 3) == 0) m_tready <= 1'b1;
        else m_tready <= (r < 60);
    end

    // Send one item, with bursts and random gaps between them
    task automatic send_item(rar_pkg::action_t act, logic [OW-1:0] an, logic [OW-1:0] ad,
                             logic [OW-1:0] bn, logic [OW-1:0] bd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= SW'({bd, bn, ad, an, act});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fsb.note_item(act, an, ad, bn, bd);
    endtask

    function automatic logic [OW-1:0] rnd_operand();
        case ($urandom_range(0, 4))
            0: return OW'($urandom_range(1, 12));
            1: return OW'(-$urandom_range(0, 12));
            2: return OW'($urandom_range(1, 255));
            3: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff;
            default: return OW'($urandom);
        endcase
    endfunction

    initial begin
        logic [OW-1:0] ext[4];
        int idle;
        ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: field extremes, every operation, zero denominators
        for (int a = 0; a < 4; a++) begin
            send_item(rar_pkg::action_t'(a), 16'd6, 16'd4, 16'd10, 16'd15);
            send_item(rar_pkg::action_t'(a), ext[a], ext[(a+1)%4], ext[(a+2)%4],
                      ext[(a+3)%4]);
            send_item(rar_pkg::action_t'(a), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
            send_item(rar_pkg::action_t'(a), 16'd3, 16'd0, 16'hfffe, 16'd5);
            send_item(rar_pkg::action_t'(a), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        end
        send_item(rar_pkg::ACT_DIV, 16'd4, 16'd9, 16'd0, 16'd3);
        // Random items
        for (int i = 0; i < 1450; i++)
            send_item(rar_pkg::action_t'($urandom_range(0, 3)), rnd_operand(),
                      rnd_operand(), rnd_operand(), rnd_operand());
        s_tvalid <= 1'b0;
        // Drain, then a quiet stretch for anything stray
        idle = 0;
        while (fsb.pending.size() != 0 && idle < 200000) begin
            @(posedge aclk);
            idle++;
        end
        repeat (400) @(posedge aclk);
        if (fsb.errors == 0 && fsb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Overall limit for ~1500 items, with stalls
    initial begin
        #4ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
